FILE: src/windowed_nearest_edge_search_unit_assert.svh
// Assertion helpers for the nearest edge search unit
`ifndef WINDOWED_NEAREST_EDGE_SEARCH_UNIT_ASSERT_SVH
`define WINDOWED_NEAREST_EDGE_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define WNES_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WNES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/wnes_pkg.sv
package wnes_pkg;

   localparam int unsigned MAX_WIDTH  = 256;
   localparam int unsigned MAX_HEIGHT = 256;
   localparam int unsigned MAX_RADIUS = 8;
   localparam int unsigned FRAC_BITS  = 4;
   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned D2_W       = 15;
   localparam int unsigned ONE_Q14    = 16384;
   localparam int unsigned RAD_MAX    = MAX_RADIUS << FRAC_BITS;

   typedef struct packed {
      logic               action;
      logic [7:0]         pixel_col;
      logic [7:0]         pixel_row;
      logic               edge_flag;
      logic signed [15:0] grad_x_in;
      logic signed [15:0] grad_y_in;
      logic [15:0]        grad_mag_in;
      logic [11:0]        query_x;
      logic [11:0]        query_y;
      logic [7:0]         search_radius;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [7:0]         match_x;
      logic [7:0]         match_y;
      logic [7:0]         match_distance;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic [15:0]        grad_mag_out;
   } rsp_type;

   typedef struct packed {
      logic        edge_flag;
      logic [15:0] gx;
      logic [15:0] gy;
      logic [15:0] mag;
   } pixel_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_QUERY,
      CMD_MISS
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      pixel_type         pix;
      logic [11:0]       qx;
      logic [11:0]       qy;
      logic [7:0]        x0;
      logic [7:0]        x1;
      logic [7:0]        y0;
      logic [7:0]        y1;
      logic [D2_W-1:0]   rad2;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_SQRT,
      ST_ROUND,
      ST_GRAD,
      ST_NORM,
      ST_PACK,
      ST_DONE
   } back_state_type;

endpackage

FILE: src/windowed_nearest_edge_search_unit.sv
// Channel | Handshake                    | Payload
// req     | req_push / req_full          | req_data (req_type)
// rsp     | rsp_pop / rsp_empty          | rsp_data (rsp_type)
// csr     | csr_psel, csr_penable, write | csr_paddr, csr_pwdata, csr_prdata
//
// A pixel write uses the memory's write port; reads have their own port.
// A query scans the clipped window of W pixels (up to 289):
// one pixel read per cycle, 8 square root steps, then normalization steps.
// After reset a clearing pass over all 65536 addresses holds req_full high.
// A two-deep command queue takes transactions while the back end works;
// a finished result holds in the output register until popped.
`include "windowed_nearest_edge_search_unit_assert.svh"

module windowed_nearest_edge_search_unit
   import wnes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [8:0]      width_ff, width_in, height_ff, height_in;
   logic            cmd_valid, cmd_pop;
   cmd_type         cmd;
   back_status_type back_status;
   csr_index_type   csr_index;

   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_pwdata[8:0];
            CSR_IMAGE_HEIGHT: height_in = csr_pwdata[8:0];
            default: begin
            end
         endcase
      end
      case (csr_index)
         CSR_IMAGE_WIDTH:  csr_prdata = {23'd0, width_ff};
         CSR_IMAGE_HEIGHT: csr_prdata = {23'd0, height_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'(MAX_WIDTH);
         height_ff <= 9'(MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   wnes_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .cfg_width   (width_ff),
      .cfg_height  (height_ff),
      .back_status (back_status),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   wnes_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .back_status (back_status),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data),
      .rsp_pop     (rsp_pop)
   );

   `WNES_ASSERT_IMPLY(a_clear_blocks, clock, reset, back_status.clearing, req_full, "accepted during clear")
   `WNES_ASSERT_NEXT(a_clear_once, clock, reset, !back_status.clearing, !back_status.clearing, "clear restarted")
   `WNES_ASSERT_IMPLY(a_miss_zero, clock, reset, !rsp_empty && !rsp_data.found, rsp_data.match_x == 8'd0 && rsp_data.match_y == 8'd0 && rsp_data.match_distance == 8'd0 && rsp_data.normal_x == 16'd0 && rsp_data.grad_mag_out == 16'd0, "nonzero miss result")
   `WNES_ASSERT_IMPLY(a_hit_range, clock, reset, !rsp_empty && rsp_data.found, rsp_data.match_distance <= 8'd128 && $signed(rsp_data.normal_x) <= 16'sd16384 && $signed(rsp_data.normal_x) >= -16'sd16384, "hit result out of range")

endmodule

FILE: src/wnes_front.sv
module wnes_front
   import wnes_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  req_type         req_data,
   input  logic [8:0]      cfg_width,
   input  logic [8:0]      cfg_height,
   input  back_status_type back_status,
   output logic            cmd_valid,
   output cmd_type         cmd,
   input  logic            cmd_pop
);

   cmd_type    cmd_q_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   logic [8:0]  wc, hc, cx, cy, x0, y0;
   logic [9:0]  x1, y1;
   logic [7:0]  rad;
   logic [8:0]  rsum;
   logic [4:0]  r;
   logic [12:0] cxs, cys;
   logic [15:0] rad_sq;
   logic        in_image;
   logic        push_ok, pop_ok;
   cmd_type     new_cmd;

   always_comb begin
      wc  = (cfg_width > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : cfg_width;
      hc  = (cfg_height > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : cfg_height;
      rad = (req_data.search_radius > 8'(RAD_MAX)) ? 8'(RAD_MAX) : req_data.search_radius;
      in_image = ({1'b0, req_data.query_x} < {wc, {FRAC_BITS{1'b0}}})
              && ({1'b0, req_data.query_y} < {hc, {FRAC_BITS{1'b0}}});
      rsum = {1'b0, rad} + 9'((1 << FRAC_BITS) - 1);
      r    = (rsum[8:FRAC_BITS] == 5'd0) ? 5'd1 : 5'(rsum[8:FRAC_BITS]);
      cxs  = {1'b0, req_data.query_x} + 13'(1 << (FRAC_BITS - 1));
      cys  = {1'b0, req_data.query_y} + 13'(1 << (FRAC_BITS - 1));
      cx   = cxs[12:FRAC_BITS];
      cy   = cys[12:FRAC_BITS];
      x0   = (cx >= 9'(r)) ? cx - 9'(r) : 9'd0;
      y0   = (cy >= 9'(r)) ? cy - 9'(r) : 9'd0;
      x1   = {1'b0, cx} + 10'(r);
      y1   = {1'b0, cy} + 10'(r);
      if (x1 > {1'b0, wc} - 10'd1) begin
         x1 = {1'b0, wc} - 10'd1;
      end
      if (y1 > {1'b0, hc} - 10'd1) begin
         y1 = {1'b0, hc} - 10'd1;
      end
      rad_sq = rad * rad;

      new_cmd.addr = {req_data.pixel_row, req_data.pixel_col};
      new_cmd.pix.edge_flag = req_data.edge_flag;
      new_cmd.pix.gx  = req_data.grad_x_in;
      new_cmd.pix.gy  = req_data.grad_y_in;
      new_cmd.pix.mag = req_data.grad_mag_in;
      new_cmd.qx   = req_data.query_x;
      new_cmd.qy   = req_data.query_y;
      new_cmd.x0   = x0[7:0];
      new_cmd.x1   = x1[7:0];
      new_cmd.y0   = y0[7:0];
      new_cmd.y1   = y1[7:0];
      new_cmd.rad2 = rad_sq[D2_W-1:0];
      if (!req_data.action) begin
         new_cmd.kind = CMD_WRITE;
      end else if (in_image) begin
         new_cmd.kind = CMD_QUERY;
      end else begin
         new_cmd.kind = CMD_MISS;
      end
   end

   assign req_full  = (count_ff == 2'd2) || back_status.clearing;
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop_ok    = cmd_pop && cmd_valid;
   assign cmd       = cmd_q_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push_ok;
      rptr_in  = rptr_ff ^ pop_ok;
      count_in = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         cmd_q_ff[wptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: src/wnes_back.sv
module wnes_back
   import wnes_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  cmd_type         cmd,
   output logic            cmd_pop,
   output back_status_type back_status,
   output logic            rsp_empty,
   output rsp_type         rsp_data,
   input  logic            rsp_pop
);

   back_state_type state_ff, state_in;

   pixel_type         store_mem [1 << ADDR_W];
   pixel_type         rd_ff;
   logic              mem_wen, mem_ren;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   pixel_type         mem_wdata;

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   cmd_type           q_ff, q_in;
   logic [7:0]        x_ff, x_in, y_ff, y_in;
   logic              issue_done_ff, issue_done_in;
   logic              p0_ff, p0_in, p1_ff, p1_in;
   logic [7:0]        p0x_ff, p0x_in, p0y_ff, p0y_in;
   logic [7:0]        p1x_ff, p1x_in, p1y_ff, p1y_in;
   logic [23:0]       sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic              bv_ff, bv_in;
   logic [D2_W-1:0]   bd_ff, bd_in;
   logic [7:0]        bx_ff, bx_in, by_ff, by_in;
   logic [3:0]        bit_ff, bit_in;
   logic [7:0]        root_ff, root_in, dist_ff, dist_in;
   logic [1:0]        ph_ff, ph_in;
   logic [30:0]       axsq_ff, axsq_in, aysq_ff, aysq_in;
   logic [31:0]       s_ff, s_in, sq_ff, sq_in;
   logic              comp_ff, comp_in;
   logic [14:0]       lo_ff, lo_in, nx_ff, nx_in, ny_ff, ny_in;
   logic [47:0]       plo_ff, plo_in, phi_ff, phi_in;
   rsp_type           res_ff, res_in, rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              scan_end, norm_last;
   logic signed [13:0] dx, dy;
   logic signed [27:0] dxsq, dysq;
   logic [24:0]       d2;
   logic [7:0]        sq_t;
   logic [15:0]       sq_tt;
   logic [16:0]       round_lim;
   logic [15:0]       ax, ay, ntt, nxs, nys;
   logic [14:0]       nt, lo_next;
   logic [30:0]       a_sq;
   logic [64:0]       lhs, rhs;

   assign scan_end  = issue_done_ff && !p0_ff && !p1_ff;
   assign norm_last = (ph_ff == 2'd3) && (bit_ff == 4'd0) && comp_ff;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign back_status.clearing = (state_ff == ST_CLEAR);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      dx    = $signed({2'b00, p0x_ff, {FRAC_BITS{1'b0}}}) - $signed({2'b00, q_ff.qx});
      dy    = $signed({2'b00, p0y_ff, {FRAC_BITS{1'b0}}}) - $signed({2'b00, q_ff.qy});
      dxsq  = dx * dx;
      dysq  = dy * dy;
      d2    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      sq_t  = root_ff | (8'd1 << bit_ff[2:0]);
      sq_tt = sq_t * sq_t;
      round_lim = 17'(root_ff * root_ff) + 17'(root_ff);
      ax    = rd_ff.gx[15] ? (~rd_ff.gx + 16'd1) : rd_ff.gx;
      ay    = rd_ff.gy[15] ? (~rd_ff.gy + 16'd1) : rd_ff.gy;
      nt    = lo_ff | (15'd1 << bit_ff);
      ntt   = {nt, 1'b0} - 16'd1;
      a_sq  = comp_ff ? aysq_ff : axsq_ff;
      lhs   = {1'b0, phi_ff, 16'd0} + {17'd0, plo_ff};
      rhs   = {4'd0, a_sq, 30'd0};
      lo_next = (lhs <= rhs) ? nt : lo_ff;
      nxs   = {1'b0, nx_ff};
      nys   = {1'b0, ny_ff};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_QUERY: state_in = ST_SCAN;
                  CMD_MISS:  state_in = ST_DONE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = bv_ff ? ST_FETCH : ST_DONE;
            end
         end
         ST_FETCH: state_in = ST_SQRT;
         ST_SQRT: begin
            if (bit_ff == 4'd0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: state_in = ST_GRAD;
         ST_GRAD: begin
            if (ph_ff == 2'd3) begin
               state_in = (s_ff == 32'd0) ? ST_PACK : ST_NORM;
            end
         end
         ST_NORM: begin
            if (norm_last) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_wen   = 1'b0;
      mem_waddr = clr_addr_ff;
      mem_wdata = '0;
      mem_ren   = 1'b0;
      mem_raddr = {y_ff, x_ff};
      clr_addr_in   = clr_addr_ff;
      q_in          = q_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      issue_done_in = issue_done_ff;
      p0_in  = 1'b0;
      p0x_in = x_ff;
      p0y_in = y_ff;
      p1_in  = 1'b0;
      p1x_in = p0x_ff;
      p1y_in = p0y_ff;
      sqx_in = dxsq[23:0];
      sqy_in = dysq[23:0];
      bv_in  = bv_ff;
      bd_in  = bd_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      bit_in = bit_ff;
      root_in = root_ff;
      dist_in = dist_ff;
      ph_in   = ph_ff;
      axsq_in = axsq_ff;
      aysq_in = aysq_ff;
      s_in    = s_ff;
      sq_in   = sq_ff;
      comp_in = comp_ff;
      lo_in   = lo_ff;
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      plo_in  = plo_ff;
      phi_in  = phi_ff;
      res_in  = res_ff;
      rsp_in  = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;

      case (state_ff)
         ST_CLEAR: begin
            mem_wen     = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_WRITE: begin
                     mem_wen   = 1'b1;
                     mem_waddr = cmd.addr;
                     mem_wdata = cmd.pix;
                  end
                  CMD_QUERY: begin
                     q_in  = cmd;
                     x_in  = cmd.x0;
                     y_in  = cmd.y0;
                     bv_in = 1'b0;
                     issue_done_in = 1'b0;
                  end
                  default: res_in = '0;
               endcase
            end
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               mem_ren = 1'b1;
               p0_in   = 1'b1;
               if (x_ff == q_ff.x1) begin
                  x_in = q_ff.x0;
                  if (y_ff == q_ff.y1) begin
                     issue_done_in = 1'b1;
                  end else begin
                     y_in = y_ff + 8'd1;
                  end
               end else begin
                  x_in = x_ff + 8'd1;
               end
            end
            p1_in = p0_ff && rd_ff.edge_flag;
            if (p1_ff && (d2 <= 25'(q_ff.rad2)) && (!bv_ff || (d2 < 25'(bd_ff)))) begin
               bv_in = 1'b1;
               bd_in = d2[D2_W-1:0];
               bx_in = p1x_ff;
               by_in = p1y_ff;
            end
            if (scan_end && !bv_ff) begin
               res_in = '0;
            end
         end
         ST_FETCH: begin
            mem_ren   = 1'b1;
            mem_raddr = {by_ff, bx_ff};
            bit_in    = 4'd7;
            root_in   = 8'd0;
         end
         ST_SQRT: begin
            if (sq_tt <= {1'b0, bd_ff}) begin
               root_in = sq_t;
            end
            bit_in = bit_ff - 4'd1;
         end
         ST_ROUND: begin
            dist_in = (17'(bd_ff) > round_lim) ? root_ff + 8'd1 : root_ff;
            ph_in   = 2'd0;
         end
         ST_GRAD: begin
            ph_in = ph_ff + 2'd1;
            case (ph_ff)
               2'd0: axsq_in = 31'(ax * ax);
               2'd1: aysq_in = 31'(ay * ay);
               2'd2: s_in = {1'b0, axsq_ff} + {1'b0, aysq_ff};
               default: begin
                  nx_in   = 15'(ONE_Q14);
                  ny_in   = 15'd0;
                  comp_in = 1'b0;
                  bit_in  = 4'd14;
                  lo_in   = 15'd0;
               end
            endcase
         end
         ST_NORM: begin
            ph_in = ph_ff + 2'd1;
            case (ph_ff)
               2'd0: sq_in  = ntt * ntt;
               2'd1: plo_in = sq_ff * s_ff[15:0];
               2'd2: phi_in = sq_ff * s_ff[31:16];
               default: begin
                  lo_in = lo_next;
                  if (bit_ff == 4'd0) begin
                     if (comp_ff) begin
                        ny_in = lo_next;
                     end else begin
                        nx_in   = lo_next;
                        comp_in = 1'b1;
                        bit_in  = 4'd14;
                        lo_in   = 15'd0;
                     end
                  end else begin
                     bit_in = bit_ff - 4'd1;
                  end
               end
            endcase
         end
         ST_PACK: begin
            res_in.found          = 1'b1;
            res_in.match_x        = bx_ff;
            res_in.match_y        = by_ff;
            res_in.match_distance = dist_ff;
            res_in.normal_x       = rd_ff.gx[15] ? (~nxs + 16'd1) : nxs;
            res_in.normal_y       = rd_ff.gy[15] ? (~nys + 16'd1) : nys;
            res_in.grad_mag_out   = rd_ff.mag;
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wen) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_ren) begin
         rd_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         issue_done_ff <= 1'b1;
         p0_ff         <= 1'b0;
         p1_ff         <= 1'b0;
         bv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         issue_done_ff <= issue_done_in;
         p0_ff         <= p0_in;
         p1_ff         <= p1_in;
         bv_ff         <= bv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      p0x_ff  <= p0x_in;
      p0y_ff  <= p0y_in;
      p1x_ff  <= p1x_in;
      p1y_ff  <= p1y_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      bd_ff   <= bd_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      bit_ff  <= bit_in;
      root_ff <= root_in;
      dist_ff <= dist_in;
      ph_ff   <= ph_in;
      axsq_ff <= axsq_in;
      aysq_ff <= aysq_in;
      s_ff    <= s_in;
      sq_ff   <= sq_in;
      comp_ff <= comp_in;
      lo_ff   <= lo_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule

FILE: dv/edge_search_checker.sv
module edge_search_checker
   import wnes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  req_type     req_data,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count,
   output int          query_count,
   output int          found_count
);

   logic [15:0] edge_map [0:65535];
   logic [47:0] grad_map [int];
   logic [8:0]  width_reg;
   logic [8:0]  height_reg;
   rsp_type     match_queue [$];

   function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
      logic [31:0] root;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         if ((root | (32'd1 << b)) * (root | (32'd1 << b)) <= v) root = root | (32'd1 << b);
      end
      return root;
   endfunction

   function automatic logic [15:0] unit_component(input longint a, input longint s);
      longint lo, hi, mid, t;
      lo = 0;
      hi = ONE_Q14;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 2 * mid - 1;
         if (t * t * s <= ((a * a) << 30)) lo = mid;
         else hi = mid - 1;
      end
      return lo[15:0];
   endfunction

   function automatic rsp_type predict_match(input req_type q);
      rsp_type res;
      longint w, h, qx, qy, rad, r, cx, cy, x0, x1, y0, y1, best, bx, by, dx, dy, d2;
      longint gx, gy, ax, ay, s, n;
      logic [47:0] g;
      res = '0;
      w = width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg;
      h = height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg;
      qx = q.query_x;
      qy = q.query_y;
      rad = q.search_radius;
      best = -1;
      bx = 0;
      by = 0;
      if (rad > RAD_MAX) rad = RAD_MAX;
      if (qx >= w * 16 || qy >= h * 16) return res;
      r = (rad + 15) / 16;
      if (r < 1) r = 1;
      cx = (qx + 8) / 16;
      cy = (qy + 8) / 16;
      y0 = cy - r < 0 ? 0 : cy - r;
      y1 = cy + r > h - 1 ? h - 1 : cy + r;
      x0 = cx - r < 0 ? 0 : cx - r;
      x1 = cx + r > w - 1 ? w - 1 : cx + r;
      for (longint y = y0; y <= y1; y++) begin
         for (longint x = x0; x <= x1; x++) begin
            if (edge_map[y * 256 + x][0]) begin
               dx = x * 16 - qx;
               dy = y * 16 - qy;
               d2 = dx * dx + dy * dy;
               if (d2 <= rad * rad && (best < 0 || d2 < best)) begin
                  best = d2;
                  bx = x;
                  by = y;
               end
            end
         end
      end
      if (best < 0) return res;
      g = grad_map.exists(by * 256 + bx) ? grad_map[by * 256 + bx] : '0;
      n = floor_sqrt(32'(best));
      if (best > n * n + n) n++;
      gx = $signed(g[47:32]);
      gy = $signed(g[31:16]);
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      s = ax * ax + ay * ay;
      res.found = 1'b1;
      res.match_x = bx[7:0];
      res.match_y = by[7:0];
      res.match_distance = n[7:0];
      res.grad_mag_out = g[15:0];
      if (s == 0) begin
         res.normal_x = 16'(ONE_Q14);
         res.normal_y = '0;
      end else begin
         res.normal_x = unit_component(ax, s);
         res.normal_y = unit_component(ay, s);
         if (gx < 0) res.normal_x = -res.normal_x;
         if (gy < 0) res.normal_y = -res.normal_y;
      end
      return res;
   endfunction

   assign pending_count = match_queue.size();

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 65536; i++) edge_map[i] = '0;
         grad_map.delete();
         match_queue.delete();
         width_reg <= 9'd256;
         height_reg <= 9'd256;
         fail_count <= 0;
         query_count <= 0;
         found_count <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = rsp_data;
            if (match_queue.size() == 0) begin
               $error("unexpected result transaction %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = match_queue.pop_front();
               if (got.found) found_count <= found_count + 1;
               if (got.found !== want.found) $error("found exp %h got %h", want.found, got.found);
               if (got.match_x !== want.match_x)
                  $error("match_x exp %h got %h", want.match_x, got.match_x);
               if (got.match_y !== want.match_y)
                  $error("match_y exp %h got %h", want.match_y, got.match_y);
               if (got.match_distance !== want.match_distance)
                  $error("match_distance exp %h got %h", want.match_distance, got.match_distance);
               if (got.normal_x !== want.normal_x)
                  $error("normal_x exp %h got %h", want.normal_x, got.normal_x);
               if (got.normal_y !== want.normal_y)
                  $error("normal_y exp %h got %h", want.normal_y, got.normal_y);
               if (got.grad_mag_out !== want.grad_mag_out)
                  $error("grad_mag_out exp %h got %h", want.grad_mag_out, got.grad_mag_out);
               if (got !== want) fail_count <= fail_count + 1;
            end
         end
         if (req_push && !req_full) begin
            if (req_data.action) begin
               match_queue = {match_queue, predict_match(req_data)};
               query_count <= query_count + 1;
            end else begin
               edge_map[{req_data.pixel_row, req_data.pixel_col}] = {15'd0, req_data.edge_flag};
               grad_map[{req_data.pixel_row, req_data.pixel_col}] =
                  {req_data.grad_x_in, req_data.grad_y_in, req_data.grad_mag_in};
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[2]))
               CSR_IMAGE_WIDTH: width_reg <= csr_pwdata[8:0];
               CSR_IMAGE_HEIGHT: height_reg <= csr_pwdata[8:0];
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: dv/testbench.sv
module testbench;
   import wnes_pkg::*;

   localparam int STALL_LIMIT = 200000;
   localparam int REQ_BITS = $bits(req_type);

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;
   int          query_count;
   int          found_count;
   int          send_idle_pct;
   int          take_idle_pct;
   int          quiet_cycles;
   logic [8:0]  cur_width;
   logic [8:0]  cur_height;

   windowed_nearest_edge_search_unit DUT (.*);

   edge_search_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= take_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_psel && csr_penable)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [8:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {23'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) cur_width = value;
      else cur_height = value;
   endtask

   task automatic set_image(input logic [8:0] w, input logic [8:0] h);
      req_push <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic send(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   function automatic req_type pixel_write(input int col, input int row, input bit is_edge);
      req_type item;
      item = req_type'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom}));
      item.action = 1'b0;
      item.pixel_col = 8'(col);
      item.pixel_row = 8'(row);
      item.edge_flag = is_edge;
      return item;
   endfunction

   function automatic req_type edge_query(input int qx, input int qy, input int rad);
      req_type item;
      item = req_type'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom}));
      item.action = 1'b1;
      item.query_x = 12'(qx);
      item.query_y = 12'(qy);
      item.search_radius = 8'(rad);
      return item;
   endfunction

   task automatic random_phase(input int count);
      int cx;
      int cy;
      req_type item;
      for (int i = 0; i < count; i++) begin
         cx = $urandom_range(255);
         cy = $urandom_range(255);
         if ($urandom_range(9) < 7) begin
            repeat ($urandom_range(4)) begin
               item = pixel_write((cx + $urandom_range(16) - 8) & 255,
                                  (cy + $urandom_range(16) - 8) & 255, $urandom_range(3) != 0);
               case ($urandom_range(5))
                  0: item.grad_x_in = '0;
                  1: item.grad_y_in = '0;
                  2: begin
                     item.grad_x_in = '0;
                     item.grad_y_in = '0;
                  end
                  default: ;
               endcase
               send(item);
            end
            send(edge_query(cx * 16 + $urandom_range(15) - 8 & 4095, cy * 16 + $urandom_range(15) & 4095,
                            $urandom_range(9) < 8 ? $urandom_range(140) : $urandom_range(255)));
         end else begin
            send(edge_query($urandom_range(4095), $urandom_range(4095), $urandom_range(255)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      cur_width = 9'd256;
      cur_height = 9'd256;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(edge_query(0, 0, 128));
      send(pixel_write(0, 0, 1'b1));
      send(pixel_write(255, 255, 1'b1));
      send(pixel_write(10, 10, 1'b1));
      send(pixel_write(11, 10, 1'b1));
      send(pixel_write(5, 5, 1'b0));
      send(edge_query(0, 0, 0));
      send(edge_query(8, 8, 16));
      send(edge_query(4095, 4095, 255));
      send(edge_query(4080, 4080, 255));
      send(edge_query(168, 160, 8));
      send(edge_query(170, 166, 200));
      send(edge_query(80, 80, 128));
      send(edge_query(240, 240, 255));

      set_image(9'd0, 9'd0);
      send(edge_query(0, 0, 128));
      set_image(9'd1, 9'd1);
      send(edge_query(0, 0, 128));
      send(edge_query(16, 0, 128));
      set_image(9'd511, 9'd300);
      send(edge_query(4095, 4095, 128));
      send(edge_query(160, 160, 128));

      send_idle_pct = 19;
      take_idle_pct = 81;
      set_image(9'd256, 9'd256);
      random_phase(110);
      send_idle_pct = 81;
      take_idle_pct = 19;
      set_image(9'd64, 9'd200);
      random_phase(70);
      send_idle_pct = 0;
      take_idle_pct = 0;
      set_image(9'd256, 9'd256);
      random_phase(110);

      req_push <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Covered %0d queries, %0d of them matched, over several image sizes.",
               query_count, found_count);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: windowed_nearest_edge_search_unit.f
+incdir+src
src/wnes_pkg.sv
src/wnes_front.sv
src/wnes_back.sv
src/windowed_nearest_edge_search_unit.sv
dv/edge_search_checker.sv
dv/testbench.sv
